### rtl/assert_macros.svh
// Assertion macros used by polyline_frame_offset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PFO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PFO_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PFO_ASSERT(lbl, prop, msg)
`define PFO_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/pfo_pkg.sv
package pfo_pkg;

    localparam int UNIT_FRAC_BITS = 16;
    localparam int UW = UNIT_FRAC_BITS + 2;
    localparam int QB = UNIT_FRAC_BITS + 1;
    localparam int NW = 31 + UNIT_FRAC_BITS;
    localparam int MW = 32;
    localparam int PW = 64;
    localparam int OW = 34;
    localparam int CW = 6;
    localparam int SQRT_STEPS = 32;
    localparam int FRM_OPS = 9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_FRM,
        ST_EMIT1,
        ST_EMIT2
    } state_t;

    function automatic logic signed [PW-1:0] round_shr(input logic signed [PW-1:0] v);
        logic [PW-1:0] m;
        begin
            m = v[PW-1] ? PW'(-v) : PW'(v);
            m = (m + (PW'(1) << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
            return v[PW-1] ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic [31:0] sat32(input logic signed [OW:0] v);
        logic signed [OW:0] hi;
        logic signed [OW:0] lo;
        begin
            hi = (OW+1)'(32'sh7FFF_FFFF);
            lo = -(OW+1)'(33'sh0_8000_0000);
            if (v > hi)
                return 32'h7FFF_FFFF;
            else if (v < lo)
                return 32'h8000_0000;
            else
                return v[31:0];
        end
    endfunction

endpackage

### rtl/polyline_frame_offset.sv
// Channel  | Direction | Word contents
// s_*      | in        | tdata: point_x, point_y, point_z; tlast: is_last
// m_*      | out       | tdata: out_x, out_y, out_z; tlast: out_last; tuser: degenerate
// cfg_*    | in        | cfg_index selects offset_right (0) or offset_up (1)
// A point after the first passes, from acceptance until ready again, through a difference
// step, normalize steps, squaring, 32 square root steps, three divisions, the frame and
// offset step and one or two emits, all on one shared multiplier and divider step under
// a small sequencer.
// A zero-length segment goes straight from normalization to the frame step.
// The first point of a polyline is stored and gives no word; a lone point goes to the last emit.
// Reset clears the control state and both offsets; no clearing pass is needed.
// A stalled output holds the sequencer in its emit state; the input is not ready
// until the last word of the current point has been loaded.
`include "assert_macros.svh"

module polyline_frame_offset (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // point_x, point_y, point_z
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // out_x, out_y, out_z
    output logic         m_tlast,
    output logic [0:0]   m_tuser,   // degenerate
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int U  = pfo_pkg::UNIT_FRAC_BITS;
    localparam int UW = pfo_pkg::UW;
    localparam int QB = pfo_pkg::QB;
    localparam int NW = pfo_pkg::NW;
    localparam int MW = pfo_pkg::MW;
    localparam int PW = pfo_pkg::PW;
    localparam int OW = pfo_pkg::OW;
    localparam int CW = pfo_pkg::CW;

    pfo_pkg::state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic signed [31:0] cur_reg [3];
    logic signed [31:0] cur_next [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] prev_next [3];
    logic last_reg, last_next;
    logic have_prev_reg, have_prev_next;
    logic [32:0] mag_reg [3];
    logic [32:0] mag_next [3];
    logic neg_reg [3];
    logic neg_next [3];
    logic [PW-1:0] n_reg, n_next, r_reg, r_next, bit_reg, bit_next;
    logic [30:0] rem_reg, rem_next;
    logic [QB-1:0] qsh_reg, qsh_next;
    logic signed [UW-1:0] u_reg [3];
    logic signed [UW-1:0] u_next [3];
    logic signed [UW-1:0] upx_reg, upx_next, upy_reg, upy_next, upz_reg, upz_next;
    logic deg_reg, deg_next;
    logic signed [PW-1:0] prod_reg, prod_next, acc_reg, acc_next;
    logic signed [OW-1:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic signed [31:0] offr_reg, offu_reg;
    logic out_valid_reg, out_valid_next;
    logic [95:0] out_data_reg, out_data_next;
    logic out_last_reg, out_last_next;
    logic out_deg_reg, out_deg_next;

    logic in_fire, out_free;
    logic [32:0] mmax;
    logic signed [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] sq_t;
    logic [31:0] div_t;
    logic div_ge;
    logic [NW-1:0] div_num;
    logic [30:0] len;
    logic signed [OW:0] sum_x, sum_y, sum_z;

    assign s_tready  = (state_reg == pfo_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_deg_reg;
    assign len       = r_reg[30:0];

    always_comb
    begin
        mmax = mag_reg[0];
        if (mag_reg[1] > mmax)
            mmax = mag_reg[1];
        if (mag_reg[2] > mmax)
            mmax = mag_reg[2];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfo_pkg::ST_IDLE:
                if (in_fire)
                begin
                    if (have_prev_reg)
                        state_next = pfo_pkg::ST_DIFF;
                    else if (s_tlast)
                        state_next = pfo_pkg::ST_EMIT2;
                end
            pfo_pkg::ST_DIFF:
                state_next = pfo_pkg::ST_NORM;
            pfo_pkg::ST_NORM:
                if (mmax == '0)
                    state_next = pfo_pkg::ST_FRM;
                else if (mmax < 33'(1) << 30 && mmax >= 33'(1) << 29)
                    state_next = pfo_pkg::ST_SQ;
            pfo_pkg::ST_SQ:
                if (cnt_reg == CW'(3))
                    state_next = pfo_pkg::ST_SQRT;
            pfo_pkg::ST_SQRT:
                if (cnt_reg == CW'(pfo_pkg::SQRT_STEPS - 1))
                    state_next = pfo_pkg::ST_DIV;
            pfo_pkg::ST_DIV:
                if (cnt_reg == CW'(QB) && comp_reg == 2'd2)
                    state_next = pfo_pkg::ST_FRM;
            pfo_pkg::ST_FRM:
                if (cnt_reg == CW'(pfo_pkg::FRM_OPS))
                    state_next = pfo_pkg::ST_EMIT1;
            pfo_pkg::ST_EMIT1:
                if (out_free)
                    state_next = last_reg ? pfo_pkg::ST_EMIT2 : pfo_pkg::ST_IDLE;
            pfo_pkg::ST_EMIT2:
                if (out_free)
                    state_next = pfo_pkg::ST_IDLE;
            default:
                state_next = pfo_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == pfo_pkg::ST_SQ)
        begin
            case (cnt_reg)
                CW'(0): mul_a = MW'(mag_reg[0][29:0]);
                CW'(1): mul_a = MW'(mag_reg[1][29:0]);
                CW'(2): mul_a = MW'(mag_reg[2][29:0]);
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end
        else if (state_reg == pfo_pkg::ST_FRM)
        begin
            case (cnt_reg)
                CW'(0): begin mul_a = MW'(u_reg[0]); mul_b = MW'(u_reg[1]); end
                CW'(1): begin mul_a = MW'(u_reg[0]); mul_b = MW'(u_reg[0]); end
                CW'(2): begin mul_a = MW'(u_reg[2]); mul_b = MW'(u_reg[2]); end
                CW'(3): begin mul_a = MW'(u_reg[2]); mul_b = MW'(u_reg[1]); end
                CW'(4): begin mul_a = offr_reg; mul_b = -MW'(u_reg[2]); end
                CW'(5): begin mul_a = offu_reg; mul_b = MW'(upx_reg); end
                CW'(6): begin mul_a = offu_reg; mul_b = MW'(upy_reg); end
                CW'(7): begin mul_a = offr_reg; mul_b = MW'(u_reg[0]); end
                CW'(8): begin mul_a = offu_reg; mul_b = MW'(upz_reg); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    always_comb
    begin
        sq_t    = r_reg + bit_reg;
        div_t   = {rem_reg, qsh_reg[QB-1]};
        div_ge  = div_t >= {1'b0, len};
        div_num = (NW'(mag_reg[comp_reg][29:0]) << U) + NW'(len >> 1);
        sum_x   = (OW+1)'(state_reg == pfo_pkg::ST_EMIT1 ? prev_reg[0] : cur_reg[0])
                  + (OW+1)'(ox_reg);
        sum_y   = (OW+1)'(state_reg == pfo_pkg::ST_EMIT1 ? prev_reg[1] : cur_reg[1])
                  + (OW+1)'(oy_reg);
        sum_z   = (OW+1)'(state_reg == pfo_pkg::ST_EMIT1 ? prev_reg[2] : cur_reg[2])
                  + (OW+1)'(oz_reg);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        comp_next = comp_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        last_next = last_reg;
        have_prev_next = have_prev_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        n_next = n_reg;
        r_next = r_reg;
        bit_next = bit_reg;
        rem_next = rem_reg;
        qsh_next = qsh_reg;
        u_next = u_reg;
        upx_next = upx_reg;
        upy_next = upy_reg;
        upz_next = upz_reg;
        deg_next = deg_reg;
        prod_next = mul_a * mul_b;
        acc_next = acc_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        oz_next = oz_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_deg_next = out_deg_reg;
        case (state_reg)
            pfo_pkg::ST_IDLE:
                if (in_fire)
                begin
                    cnt_next = '0;
                    comp_next = '0;
                    last_next = s_tlast;
                    if (have_prev_reg)
                    begin
                        cur_next[0] = s_tdata[31:0];
                        cur_next[1] = s_tdata[63:32];
                        cur_next[2] = s_tdata[95:64];
                        if (s_tlast)
                            have_prev_next = 1'b0;
                    end
                    else if (s_tlast)
                    begin
                        cur_next[0] = s_tdata[31:0];
                        cur_next[1] = s_tdata[63:32];
                        cur_next[2] = s_tdata[95:64];
                        ox_next = '0;
                        oy_next = '0;
                        oz_next = '0;
                        deg_next = 1'b0;
                    end
                    else
                    begin
                        prev_next[0] = s_tdata[31:0];
                        prev_next[1] = s_tdata[63:32];
                        prev_next[2] = s_tdata[95:64];
                        have_prev_next = 1'b1;
                    end
                end
            pfo_pkg::ST_DIFF:
                for (int i = 0; i < 3; i++)
                begin
                    logic signed [32:0] d;
                    d = 33'(cur_reg[i]) - 33'(prev_reg[i]);
                    neg_next[i] = d[32];
                    mag_next[i] = d[32] ? 33'(-d) : 33'(d);
                end
            pfo_pkg::ST_NORM:
                if (mmax == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        u_next[i] = '0;
                    deg_next = 1'b1;
                    cnt_next = '0;
                end
                else if (mmax >= 33'(1) << 30)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                end
                else if (mmax < 33'(1) << 25)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] << 4;
                end
                else if (mmax < 33'(1) << 29)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] << 1;
                end
                else
                begin
                    deg_next = 1'b0;
                    cnt_next = '0;
                end
            pfo_pkg::ST_SQ:
            begin
                cnt_next = cnt_reg + CW'(1);
                case (cnt_reg)
                    CW'(1): acc_next = prod_reg;
                    CW'(2): acc_next = acc_reg + prod_reg;
                    CW'(3):
                    begin
                        n_next = PW'(acc_reg + prod_reg);
                        r_next = '0;
                        bit_next = PW'(1) << 62;
                        cnt_next = '0;
                    end
                    default: acc_next = acc_reg;
                endcase
            end
            pfo_pkg::ST_SQRT:
            begin
                if (n_reg >= sq_t)
                begin
                    n_next = n_reg - sq_t;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                    r_next = r_reg >> 1;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(pfo_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next = '0;
                    comp_next = '0;
                end
            end
            pfo_pkg::ST_DIV:
                if (cnt_reg == '0)
                begin
                    rem_next = 31'(div_num >> QB);
                    qsh_next = div_num[QB-1:0];
                    cnt_next = CW'(1);
                end
                else
                begin
                    rem_next = div_ge ? 31'(div_t - {1'b0, len}) : div_t[30:0];
                    qsh_next = {qsh_reg[QB-2:0], div_ge};
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg == CW'(QB))
                    begin
                        u_next[comp_reg] = neg_reg[comp_reg] ? -UW'(qsh_next) : UW'(qsh_next);
                        comp_next = comp_reg + 2'd1;
                        cnt_next = '0;
                    end
                end
            pfo_pkg::ST_FRM:
            begin
                cnt_next = cnt_reg + CW'(1);
                case (cnt_reg)
                    CW'(1): upx_next = UW'(pfo_pkg::round_shr(-prod_reg));
                    CW'(2): acc_next = prod_reg;
                    CW'(3): upy_next = UW'(pfo_pkg::round_shr(acc_reg + prod_reg));
                    CW'(4): upz_next = UW'(pfo_pkg::round_shr(-prod_reg));
                    CW'(5): acc_next = prod_reg;
                    CW'(6): ox_next = OW'(pfo_pkg::round_shr(acc_reg + prod_reg));
                    CW'(7): oy_next = OW'(pfo_pkg::round_shr(prod_reg));
                    CW'(8): acc_next = prod_reg;
                    CW'(9): oz_next = OW'(pfo_pkg::round_shr(acc_reg + prod_reg));
                    default: acc_next = acc_reg;
                endcase
            end
            pfo_pkg::ST_EMIT1, pfo_pkg::ST_EMIT2:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {pfo_pkg::sat32(sum_z), pfo_pkg::sat32(sum_y),
                                     pfo_pkg::sat32(sum_x)};
                    out_last_next = (state_reg == pfo_pkg::ST_EMIT2);
                    out_deg_next = deg_reg;
                    if (state_reg == pfo_pkg::ST_EMIT1)
                        prev_next = cur_reg;
                end
            default:
                cnt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfo_pkg::ST_IDLE;
            cnt_reg <= '0;
            comp_reg <= '0;
            have_prev_reg <= 1'b0;
            last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            offr_reg <= '0;
            offu_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            comp_reg <= comp_next;
            have_prev_reg <= have_prev_next;
            last_reg <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready && cfg_index == 8'd0)
                offr_reg <= cfg_data;
            if (cfg_valid && cfg_ready && cfg_index == 8'd1)
                offu_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        n_reg <= n_next;
        r_reg <= r_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        qsh_reg <= qsh_next;
        u_reg <= u_next;
        upx_reg <= upx_next;
        upy_reg <= upy_next;
        upz_reg <= upz_next;
        deg_reg <= deg_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        oz_reg <= oz_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_deg_reg <= out_deg_next;
    end

    `PFO_ASSERT(a_div_rem, (state_reg == pfo_pkg::ST_DIV && cnt_reg != '0) |-> (rem_reg < len), "division remainder not below length")
    `PFO_ASSERT(a_norm_range, (state_reg == pfo_pkg::ST_SQ) |-> (mmax < 33'(1) << 30 && mmax >= 33'(1) << 29), "segment not normalized")
    `PFO_ASSERT(a_quot_range, (state_reg == pfo_pkg::ST_DIV && cnt_reg == CW'(QB)) |-> (qsh_next <= QB'(1) << U), "unit component too large")
    `PFO_ASSERT_NEXT(a_zero_seg, (state_reg == pfo_pkg::ST_NORM && mmax == '0), (state_reg == pfo_pkg::ST_FRM && deg_reg), "zero segment not flagged")

endmodule
